### design/quoted_argument_tokenizer_macros.svh
// Assertion helpers for the argument tokenizer.
// Each macro compiles to nothing when SYNTHESIS is set.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define QAT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset
`define QAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define QAT_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define QAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### design/qat_pkg.sv
package qat_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_END    = 8'h00;

    // Divider slots and argument limit
    localparam int unsigned MAX_DIVIDERS = 4;
    localparam int unsigned DIV_SLOTS    = 4;
    localparam int unsigned MAX_ARGS     = 16;
    localparam logic [4:0]  LIM_CAP      = 5'((MAX_ARGS > 31) ? 31 : MAX_ARGS);

    // Length of the held escape sequence (backslash, u, 0, 0, 2)
    localparam logic [2:0] SEQ_LEN = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIVIDER_BYTES = 2'd0;
    localparam logic [1:0] CFG_DIVIDER_COUNT = 2'd1;
    localparam logic [1:0] CFG_MAX_ARGS      = 2'd2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_ARG_END  = 2'd1,
        KIND_CMD_END  = 2'd2,
        KIND_CMD_DROP = 2'd3
    } kind_t;

    // Parser state carried between bytes
    typedef struct packed {
        logic       in_arg;
        logic       in_quotes;
        logic       esc_armed;
        logic [4:0] arg_count;
        logic [2:0] unesc_prog;
        logic       limit_hit;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        in_arg:     1'b0,
        in_quotes:  1'b0,
        esc_armed:  1'b1,
        arg_count:  5'd0,
        unesc_prog: 3'd0,
        limit_hit:  1'b0
    };

    // Results caused by one byte: held bytes, one decoded byte, markers
    typedef struct packed {
        logic [2:0] flush_cnt;
        logic       byte_vld;
        logic [7:0] byte_val;
        logic       mark_vld;
        logic       end_vld;
        logic       end_drop;
        logic [3:0] idx;
        logic [4:0] total;
    } burst_t;

    // Held escape bytes in order
    function automatic logic [7:0] seq_byte(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_U;
            3'd2:    r = CH_ZERO;
            3'd3:    r = CH_ZERO;
            3'd4:    r = CH_TWO;
            default: r = CH_END;
        endcase
        return r;
    endfunction

endpackage

### design/quoted_argument_tokenizer.sv
// Quoted argument tokenizer: takes one byte of command text per input transfer and
// returns the argument bytes and markers it causes, one result per cycle while
// m_ready is high. A byte is accepted in every cycle while m_ready is high and each
// byte yields at most one result; a byte that yields several (up to seven: held
// escape bytes, an argument end and a command end) keeps the result port busy until
// all have left the single burst register, and the next byte is taken in the cycle
// its last result transfers. Configuration writes are always accepted and take
// effect for the next byte; write them only while no results are pending.
`include "quoted_argument_tokenizer_macros.svh"

module quoted_argument_tokenizer (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    // text bytes in
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    // results out
    output logic                m_valid,
    input  logic                m_ready,
    output qat_pkg::kind_t      m_kind,
    output logic [7:0]          m_out_byte,
    output logic [3:0]          m_arg_index,
    output logic [4:0]          m_arg_total,
    output logic                m_last
);
    import qat_pkg::*;

    logic [31:0]  divider_bytes_reg;
    logic [2:0]   divider_count_reg;
    logic [4:0]   max_args_reg;
    parse_state_t st_reg, st_next;
    burst_t       burst_reg, burst_new;
    logic [2:0]   pos_reg;
    logic [3:0]   remaining;
    logic         s_xfer, m_xfer;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_bytes_reg <= 32'd32;
            divider_count_reg <= 3'd1;
            max_args_reg      <= 5'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIVIDER_BYTES: divider_bytes_reg <= cfg_data;
                CFG_DIVIDER_COUNT: divider_count_reg <= cfg_data[2:0];
                CFG_MAX_ARGS:      max_args_reg      <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    qat_parse u_parse (
        .st            (st_reg),
        .text_byte     (s_text_byte),
        .divider_bytes (divider_bytes_reg),
        .divider_count (divider_count_reg),
        .max_args      (max_args_reg),
        .st_next       (st_next),
        .burst         (burst_new)
    );

    // Results left in the burst register
    assign remaining = 4'(burst_reg.flush_cnt - pos_reg) + 4'(burst_reg.byte_vld)
                     + 4'(burst_reg.mark_vld) + 4'(burst_reg.end_vld);
    assign m_valid = (remaining != 4'd0);
    assign m_last  = (remaining == 4'd1);
    assign s_ready = !m_valid || (m_ready && m_last);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= PARSE_RESET;
        end else if (s_xfer) begin
            st_reg <= st_next;
        end
    end

    // Burst register and drain position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg <= '0;
            pos_reg   <= 3'd0;
        end else if (s_xfer) begin
            burst_reg <= burst_new;
            pos_reg   <= 3'd0;
        end else if (m_xfer) begin
            if (pos_reg < burst_reg.flush_cnt) begin
                pos_reg <= 3'(pos_reg + 3'd1);
            end else if (burst_reg.byte_vld) begin
                burst_reg.byte_vld <= 1'b0;
            end else if (burst_reg.mark_vld) begin
                burst_reg.mark_vld <= 1'b0;
            end else begin
                burst_reg.end_vld <= 1'b0;
            end
        end
    end

    // Result selection: held bytes, decoded byte, argument end, command end
    always_comb begin
        m_kind      = KIND_BYTE;
        m_out_byte  = 8'd0;
        m_arg_index = burst_reg.idx;
        m_arg_total = 5'd0;
        if (pos_reg < burst_reg.flush_cnt) begin
            m_out_byte = seq_byte(pos_reg);
        end else if (burst_reg.byte_vld) begin
            m_out_byte = burst_reg.byte_val;
        end else if (burst_reg.mark_vld) begin
            m_kind = KIND_ARG_END;
        end else begin
            m_kind      = burst_reg.end_drop ? KIND_CMD_DROP : KIND_CMD_END;
            m_arg_index = burst_reg.total[3:0];
            m_arg_total = burst_reg.total;
        end
    end

    // Checks
    `QAT_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `QAT_ASSERT_NOW(a_pos_in_range, aclk, aresetn, 1'b1, pos_reg <= burst_reg.flush_cnt)
    `QAT_ASSERT_NOW(a_prog_in_range, aclk, aresetn, 1'b1, st_reg.unesc_prog <= SEQ_LEN)
    `QAT_ASSERT_NOW(a_cmd_end_last, aclk, aresetn,
        m_valid && (m_kind == KIND_CMD_END || m_kind == KIND_CMD_DROP), m_last)
    `QAT_ASSERT_NEXT(a_drained, aclk, aresetn, m_xfer && m_last && !s_xfer, !m_valid)

endmodule

### design/qat_parse.sv
module qat_parse (
    input  qat_pkg::parse_state_t st,
    input  logic [7:0]            text_byte,
    input  logic [31:0]           divider_bytes,
    input  logic [2:0]            divider_count,
    input  logic [4:0]            max_args,
    output qat_pkg::parse_state_t st_next,
    output qat_pkg::burst_t       burst
);
    import qat_pkg::*;

    logic [4:0] lim;
    logic       is_div;
    logic       lim_now;

    // Effective argument limit
    assign lim     = (max_args > LIM_CAP) ? LIM_CAP : max_args;
    assign lim_now = st.limit_hit || (st.arg_count >= lim);

    // Divider match over the enabled slots
    always_comb begin
        is_div = 1'b0;
        for (int k = 0; k < DIV_SLOTS; k++) begin
            if (k < MAX_DIVIDERS && 3'(k) < divider_count &&
                text_byte == divider_bytes[8*k +: 8]) begin
                is_div = 1'b1;
            end
        end
    end

    // Next state and result burst for this byte
    always_comb begin
        logic [7:0] want;
        want    = (st.unesc_prog == 3'd4) ? CH_TWO : CH_ZERO;
        st_next = st;
        st_next.limit_hit = lim_now;
        burst           = '0;
        burst.byte_val  = text_byte;
        burst.idx       = st.arg_count[3:0];
        burst.total     = st.arg_count;

        if (text_byte == CH_END) begin
            // command end
            burst.end_vld = 1'b1;
            if (st.in_arg) begin
                burst.flush_cnt = st.unesc_prog;
            end
            if (st.in_arg && st.in_quotes) begin
                burst.end_drop = 1'b1;
            end else if (st.in_arg) begin
                burst.mark_vld = 1'b1;
                burst.total    = 5'(st.arg_count + 5'd1);
            end
            st_next = PARSE_RESET;
        end else if (lim_now) begin
            // ignored until command end
        end else if (is_div && !st.in_quotes) begin
            if (st.in_arg) begin
                burst.flush_cnt    = st.unesc_prog;
                burst.mark_vld     = 1'b1;
                st_next.arg_count  = 5'(st.arg_count + 5'd1);
                st_next.in_arg     = 1'b0;
                st_next.unesc_prog = 3'd0;
                st_next.limit_hit  = (5'(st.arg_count + 5'd1) >= lim);
            end
        end else begin
            // quote and escape tracking
            if (!st.in_arg) begin
                st_next.in_arg = 1'b1;
                if (text_byte == CH_QUOTE) begin
                    st_next.in_quotes = 1'b1;
                    st_next.esc_armed = 1'b1;
                end
            end else if (st.in_quotes && !is_div) begin
                if (text_byte == CH_QUOTE) begin
                    if (st.esc_armed) begin
                        st_next.in_quotes = 1'b0;
                    end else begin
                        st_next.esc_armed = 1'b1;
                    end
                end else if (text_byte == CH_BSLASH) begin
                    st_next.esc_armed = !st.esc_armed;
                end else begin
                    st_next.esc_armed = 1'b1;
                end
            end

            // unescape of backslash-u-0-0-2-0
            case (st.unesc_prog)
                3'd0: begin
                    if (text_byte == CH_BSLASH) begin
                        st_next.unesc_prog = 3'd1;
                    end else begin
                        burst.byte_vld = 1'b1;
                    end
                end
                3'd1: begin
                    if (text_byte == CH_U) begin
                        st_next.unesc_prog = 3'd2;
                    end else begin
                        burst.flush_cnt    = 3'd1;
                        burst.byte_vld     = 1'b1;
                        st_next.unesc_prog = 3'd0;
                    end
                end
                default: begin
                    if (text_byte == want) begin
                        if (st.unesc_prog >= SEQ_LEN) begin
                            burst.byte_vld     = 1'b1;
                            burst.byte_val     = CH_SPACE;
                            st_next.unesc_prog = 3'd0;
                        end else begin
                            st_next.unesc_prog = 3'(st.unesc_prog + 3'd1);
                        end
                    end else begin
                        burst.flush_cnt = st.unesc_prog;
                        if (text_byte == CH_BSLASH) begin
                            st_next.unesc_prog = 3'd1;
                        end else begin
                            burst.byte_vld     = 1'b1;
                            st_next.unesc_prog = 3'd0;
                        end
                    end
                end
            endcase
        end
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import qat_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 10;
    localparam int ARG_CAP      = 16;
    localparam int DIV_CAP      = 4;

    // One expected result of the tokenizer
    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic [3:0] index;
        logic [4:0] total;
        logic       last;
    } token_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_DIVIDER_BYTES;
    logic [31:0] cfg_data    = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    kind_t       m_kind;
    logic [7:0]  m_out_byte;
    logic [3:0]  m_arg_index;
    logic [4:0]  m_arg_total;
    logic        m_last;

    quoted_argument_tokenizer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_byte  (m_out_byte),
        .m_arg_index (m_arg_index),
        .m_arg_total (m_arg_total),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Expected tokens, oldest first, and the ones built for the current byte
    token_t expected_tokens[$];
    token_t byte_tokens[$];
    int     mismatches  = 0;
    int     cycle_count = 0;
    bit     tx_idle_on  = 1'b1;
    bit     rx_idle_on  = 1'b1;

    // Shadow registers
    logic [31:0] div_bytes = 32'h0000_0020;
    logic [2:0]  div_count = 3'd1;
    logic [4:0]  arg_limit = 5'd8;

    // Shadow parser state
    logic       in_arg    = 1'b0;
    logic       in_quotes = 1'b0;
    logic       esc_armed = 1'b1;
    logic [4:0] arg_cnt   = '0;
    logic [2:0] hold_n    = '0;
    logic       limit_hit = 1'b0;

    function automatic logic [7:0] esc_char(input logic [2:0] k);
        case (k)
            3'd0:    return CH_BSLASH;
            3'd1:    return CH_U;
            3'd4:    return CH_TWO;
            default: return CH_ZERO;
        endcase
    endfunction

    function automatic void add_token(input kind_t k, input logic [7:0] b,
                                      input logic [4:0] tot);
        token_t t;
        t.kind  = k;
        t.value = b;
        t.index = arg_cnt[3:0];
        t.total = tot;
        t.last  = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    // Release held escape bytes unchanged
    function automatic void flush_held();
        for (int k = 0; k < hold_n; k++)
            add_token(KIND_BYTE, esc_char(k[2:0]), 5'd0);
        hold_n = '0;
    endfunction

    // Escape decoding: backslash u 0 0 2 0 becomes a space
    function automatic void decode_char(input logic [7:0] c);
        logic [7:0] want;
        if (hold_n == 3'd0) begin
            if (c == CH_BSLASH) hold_n = 3'd1;
            else add_token(KIND_BYTE, c, 5'd0);
        end else if (hold_n == 3'd1) begin
            if (c == CH_U) begin
                hold_n = 3'd2;
            end else begin
                add_token(KIND_BYTE, CH_BSLASH, 5'd0);
                add_token(KIND_BYTE, c, 5'd0);
                hold_n = 3'd0;
            end
        end else begin
            want = (hold_n == 3'd4) ? CH_TWO : CH_ZERO;
            if (c == want) begin
                if (hold_n >= 3'd5) begin
                    add_token(KIND_BYTE, CH_SPACE, 5'd0);
                    hold_n = 3'd0;
                end else begin
                    hold_n = hold_n + 3'd1;
                end
            end else begin
                flush_held();
                if (c == CH_BSLASH) hold_n = 3'd1;
                else add_token(KIND_BYTE, c, 5'd0);
            end
        end
    endfunction

    function automatic bit divider_hit(input logic [7:0] c);
        int n;
        n = div_count;
        if (n > DIV_CAP) n = DIV_CAP;
        for (int k = 0; k < n; k++)
            if (div_bytes[8*k +: 8] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void reset_parser();
        in_arg    = 1'b0;
        in_quotes = 1'b0;
        esc_armed = 1'b1;
        arg_cnt   = '0;
        hold_n    = '0;
        limit_hit = 1'b0;
    endfunction

    // Work out the tokens one accepted text byte causes
    function automatic void predict_tokens(input logic [7:0] b);
        logic [4:0] lim;
        lim = (arg_limit > ARG_CAP) ? 5'(ARG_CAP) : arg_limit;
        byte_tokens.delete();
        if (arg_cnt >= lim) limit_hit = 1'b1;

        if (b == CH_END) begin
            if (in_arg && in_quotes) begin
                flush_held();
                add_token(KIND_CMD_DROP, 8'h00, arg_cnt);
            end else begin
                if (in_arg) begin
                    flush_held();
                    add_token(KIND_ARG_END, 8'h00, 5'd0);
                    arg_cnt = arg_cnt + 5'd1;
                end
                add_token(KIND_CMD_END, 8'h00, arg_cnt);
            end
            reset_parser();
        end else if (limit_hit) begin
            // ignored until the command ends
        end else if (divider_hit(b) && !in_quotes) begin
            if (in_arg) begin
                flush_held();
                add_token(KIND_ARG_END, 8'h00, 5'd0);
                arg_cnt = arg_cnt + 5'd1;
                in_arg  = 1'b0;
                if (arg_cnt >= lim) limit_hit = 1'b1;
            end
        end else begin
            if (!in_arg) begin
                in_arg = 1'b1;
                if (b == CH_QUOTE) begin
                    in_quotes = 1'b1;
                    esc_armed = 1'b1;
                end
            end else if (in_quotes && !divider_hit(b)) begin
                if (b == CH_QUOTE) begin
                    if (esc_armed) in_quotes = 1'b0;
                    else esc_armed = 1'b1;
                end else if (b == CH_BSLASH) begin
                    esc_armed = !esc_armed;
                end else begin
                    esc_armed = 1'b1;
                end
            end
            decode_char(b);
        end

        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    // Sender side: optional gap, then one text byte transfer
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tokens(b);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    // Wait until all expected tokens are out, plus a short hold-off
    task automatic wait_drain();
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_DIVIDER_BYTES: div_bytes = data;
            CFG_DIVIDER_COUNT: div_count = data[2:0];
            CFG_MAX_ARGS:      arg_limit = data[4:0];
            default: ;
        endcase
    endtask

    // Register writes only once the block is idle; unused upper bits carry noise
    task automatic set_config(input logic [31:0] dbytes, input logic [2:0] dcount,
                              input logic [4:0] maxa);
        s_valid <= 1'b0;
        wait_drain();
        write_reg(CFG_DIVIDER_BYTES, dbytes);
        write_reg(CFG_DIVIDER_COUNT, ({$urandom()} & ~32'h7) | 32'(dcount));
        write_reg(CFG_MAX_ARGS, ({$urandom()} & ~32'h1F) | 32'(maxa));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_divider();
        int n;
        logic [7:0] b;
        n = (div_count > DIV_CAP) ? DIV_CAP : div_count;
        if (n == 0) return 8'($urandom_range(1, 255));
        b = div_bytes[8*$urandom_range(0, n-1) +: 8];
        if (b == CH_END) b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    // One command: random tokens of escapes, quotes, dividers and noise, then end
    task automatic send_command(output int nsent);
        logic [7:0] txt[$];
        int ntok;
        int plen;
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0: begin
                    for (int k = 0; k < 5; k++) txt.push_back(esc_char(k[2:0]));
                    txt.push_back(CH_ZERO);
                end
                1: begin
                    plen = $urandom_range(1, 5);
                    for (int k = 0; k < plen; k++) txt.push_back(esc_char(k[2:0]));
                end
                2: txt.push_back(CH_QUOTE);
                3, 4: txt.push_back(pick_divider());
                5: txt.push_back(CH_BSLASH);
                6: txt.push_back(8'($urandom_range(8'h61, 8'h7A)));
                7: txt.push_back(8'($urandom_range(1, 255)));
                8: begin
                    txt.push_back(CH_BSLASH);
                    txt.push_back(CH_QUOTE);
                end
                default: repeat ($urandom_range(1, 4))
                    txt.push_back(8'($urandom_range(8'h41, 8'h5A)));
            endcase
        end
        txt.push_back(CH_END);
        foreach (txt[i]) send_byte(txt[i]);
        nsent = txt.size();
    endtask

    task automatic run_phase(input logic [31:0] dbytes, input logic [2:0] dcount,
                             input logic [4:0] maxa, input int nitems, input bit idle_ok);
        int sent;
        int k;
        set_config(dbytes, dcount, maxa);
        tx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
        rx_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
        sent = 0;
        while (sent < nitems) begin
            send_command(k);
            sent += k;
        end
    endtask

    // Escape decoding, broken sequences, quotes and byte extremes at reset settings
    task automatic test_directed_text();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_text("\\u0020\\q\\u0\\ \"a \\\"\"");
        send_byte(8'hFF);
        send_byte(CH_END);
        // unterminated quote with held escape bytes
        send_text("\"\\u");
        send_byte(CH_END);
    endtask

    // Divider sets: all ones, all zeros, none in use, saturated count
    task automatic test_divider_sets();
        run_phase(32'hFFFF_FFFF, 3'd7, 5'd8, 10, 1'b1);
        run_phase(32'h0000_0000, 3'd4, 5'd16, 8, 1'b1);
        run_phase($urandom(), 3'd4, 5'd16, 10, 1'b1);
        run_phase($urandom(), 3'd0, 5'd8, 8, 1'b1);
        run_phase({$urandom()} | 32'h0000_0020, 3'd2, 5'd31, 10, 1'b1);
    endtask

    // Argument limits: zero, one, small, cap and a random value up to the cap
    task automatic test_argument_limits();
        run_phase(32'h2C3B_2C20, 3'd2, 5'd0, 8, 1'b1);
        run_phase(32'h2C3B_2C20, 3'd3, 5'd1, 10, 1'b1);
        run_phase($urandom(), 3'($urandom_range(1, 4)), 5'd2, 8, 1'b1);
        run_phase($urandom(), 3'($urandom_range(1, 4)), 5'd16, 8, 1'b1);
        run_phase($urandom(), 3'd1, 5'($urandom_range(1, 16)), 8, 1'b1);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        run_phase({$urandom()} | 32'h0000_0020, 3'($urandom_range(1, 4)),
                  5'($urandom_range(1, 16)), 30, 1'b0);
    endtask

    // Result side stalls in random bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!rx_idle_on) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 1) == 1);
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_tokens
        token_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected token: kind %0d byte %h index %0d total %0d last %0b",
                             m_kind, m_out_byte, m_arg_index, m_arg_total, m_last);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                if (m_kind !== want.kind || m_out_byte !== want.value ||
                    m_arg_index !== want.index || m_arg_total !== want.total ||
                    m_last !== want.last) begin
                    if (mismatches < 10)
                        $display({"token mismatch (exp/got): kind %0d/%0d byte %h/%h ",
                                  "index %0d/%0d total %0d/%0d last %0b/%0b"},
                                 want.kind, m_kind, want.value, m_out_byte,
                                 want.index, m_arg_index, want.total, m_arg_total,
                                 want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_text();
        test_divider_sets();
        test_argument_limits();
        test_steady_stream();
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### quoted_argument_tokenizer.f
+incdir+design
design/qat_pkg.sv
design/qat_parse.sv
design/quoted_argument_tokenizer.sv
tb/sv/tb.sv
